// ===== hw/rtl/pru_pkg.sv =====
package pru_pkg;

    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } filt_t;

    localparam logic [7:0] FILT_CODE_MAX = 8'd4;
    localparam logic [3:0] BPP_RESET     = 4'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       row_start;
        logic       first_row;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] pixel_byte;
        logic       bad_filter;
        logic       row_overflow;
    } out_beat_t;

    // one item held in the reconstruction stage
    typedef struct packed {
        logic [7:0] data_byte;
        logic       row_start;
        filt_t      mode;
        logic       mode_err;
        logic       above_zero;
        logic       over;
    } stage_item_t;

    typedef struct packed {
        logic       en;
        logic [7:0] data;
    } store_wr_t;

endpackage

// ===== hw/rtl/pru_row_store.sv =====
module pru_row_store
    import pru_pkg::*;
#(
    parameter int DEPTH = 8192,
    parameter int AW    = 13
) (
    input  logic          aclk,
    input  store_wr_t     wr,
    input  logic [AW-1:0] wr_addr,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr_addr] <= wr.data;
        end
    end

    // hold the last read while the stage stalls
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/pru_recon.sv =====
module pru_recon
    import pru_pkg::*;
#(
    parameter int MAX_PIXEL_BYTES = 8,
    parameter int AW              = 13
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          load,
    input  stage_item_t   item_in,
    input  logic [AW-1:0] addr_in,
    input  logic [7:0]    above_rd,
    input  logic [3:0]    bpp,
    output logic          stage_ready,
    output store_wr_t     wr,
    output logic [AW-1:0] wr_addr,
    output logic          m_valid,
    input  logic          m_ready,
    output out_beat_t     m_data
);

    localparam int IW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
    localparam logic [3:0] MAX_DIST = 4'(MAX_PIXEL_BYTES);

    stage_item_t   item_reg;
    logic          valid_reg;
    logic [AW-1:0] addr_reg;
    logic [7:0]    left_reg [MAX_PIXEL_BYTES];
    logic [7:0]    ul_reg   [MAX_PIXEL_BYTES];
    logic          m_valid_reg;
    out_beat_t     m_data_reg;

    logic       advance;
    logic [3:0] span;
    logic [3:0] dist_m1;
    logic [IW-1:0] idx;
    logic [7:0] a, b, c, r;

    function automatic logic [7:0] paeth(input logic [7:0] pa_a, input logic [7:0] pa_b,
                                         input logic [7:0] pa_c);
        logic signed [9:0] da, db, dc;
        logic [9:0] ma, mb, mc;
        da = $signed({2'b00, pa_b}) - $signed({2'b00, pa_c});
        db = $signed({2'b00, pa_a}) - $signed({2'b00, pa_c});
        dc = da + db;
        ma = (da < 0) ? 10'(-da) : 10'(da);
        mb = (db < 0) ? 10'(-db) : 10'(db);
        mc = (dc < 0) ? 10'(-dc) : 10'(dc);
        if (ma <= mb && ma <= mc) begin
            return pa_a;
        end else if (mb <= mc) begin
            return pa_b;
        end
        return pa_c;
    endfunction

    // a filter-type beat makes no result, so it never waits on the output
    assign advance     = valid_reg && (item_reg.row_start || !m_valid_reg || m_ready);
    assign stage_ready = !valid_reg || advance;

    always_comb begin
        if (bpp == 4'd0) begin
            span = 4'd1;
        end else if (bpp > MAX_DIST) begin
            span = MAX_DIST;
        end else begin
            span = bpp;
        end
    end

    assign dist_m1 = span - 4'd1;
    assign idx     = dist_m1[IW-1:0];
    assign a       = left_reg[idx];
    assign c       = ul_reg[idx];
    assign b       = (item_reg.above_zero || item_reg.over) ? 8'd0 : above_rd;

    always_comb begin
        case (item_reg.mode)
            FILT_SUB:   r = item_reg.data_byte + a;
            FILT_UP:    r = item_reg.data_byte + b;
            FILT_AVG:   r = item_reg.data_byte + 8'(({1'b0, a} + {1'b0, b}) >> 1);
            FILT_PAETH: r = item_reg.data_byte + paeth(a, b, c);
            default:    r = item_reg.data_byte;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (advance) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= item_in;
            addr_reg <= addr_in;
        end
    end

    // windows: clear at row start, otherwise shift in newest first
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
                left_reg[k] <= 8'd0;
                ul_reg[k]   <= 8'd0;
            end
        end else if (advance) begin
            if (item_reg.row_start) begin
                for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
                    left_reg[k] <= 8'd0;
                    ul_reg[k]   <= 8'd0;
                end
            end else begin
                for (int k = MAX_PIXEL_BYTES - 1; k > 0; k--) begin
                    left_reg[k] <= left_reg[k-1];
                    ul_reg[k]   <= ul_reg[k-1];
                end
                left_reg[0] <= r;
                ul_reg[0]   <= b;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && !item_reg.row_start) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && !item_reg.row_start) begin
            m_data_reg.pixel_byte   <= r;
            m_data_reg.bad_filter   <= item_reg.mode_err;
            m_data_reg.row_overflow <= item_reg.over;
        end
    end

    assign wr.en   = advance && !item_reg.row_start && !item_reg.over;
    assign wr.data = r;
    assign wr_addr = addr_reg;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== hw/rtl/png_row_unfilter_top.sv =====
// PNG row unfilter: None, Sub, Up, Average and Paeth reconstruction, one byte per beat.
// Throughput: one input beat per cycle while the result output is not held off, set by the left-byte loop in the stage.
// An accepted data beat is held in the stage register, then in the output register that drives m_valid.
// Filter-type beats pass through the stage and produce no result beat.
// Reset (aresetn low, synchronous): pipeline empty, windows zero, mode None, above row zero,
// bytes_per_pixel 3. The row store is not cleared; no clearing pass is needed.
module png_row_unfilter_top
    import pru_pkg::*;
#(
    parameter int MAX_ROW_BYTES   = 8192,
    parameter int MAX_PIXEL_BYTES = 8
) (
    input  logic       aclk,
    input  logic       aresetn,
    // input beats
    input  logic       s_valid,
    output logic       s_ready,
    input  in_beat_t   s_data,
    // result beats
    output logic       m_valid,
    input  logic       m_ready,
    output out_beat_t  m_data,
    // bytes_per_pixel register write
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [3:0] cfg_data
);

    localparam int AW = $clog2(MAX_ROW_BYTES);
    // position counter must also hold MAX_ROW_BYTES itself (saturated)
    localparam int PW = $clog2(MAX_ROW_BYTES + 1);
    localparam logic [PW-1:0] POS_MAX = PW'(MAX_ROW_BYTES);

    logic [3:0]    bpp_reg;
    logic [PW-1:0] pos_reg;
    filt_t         mode_reg;
    logic          mode_err_reg;
    logic          above_zero_reg;

    logic          accept;
    logic          over;
    logic          stage_ready;
    stage_item_t   item;
    store_wr_t     wr;
    logic [AW-1:0] wr_addr;
    logic [7:0]    above_rd;

    // the register is always writable; the user must make writes only while idle, as the block has no check for it
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpp_reg <= BPP_RESET;
        end else if (cfg_valid && cfg_ready) begin
            bpp_reg <= cfg_data;
        end
    end

    // take a new beat whenever the stage is empty or drains this cycle
    assign s_ready = stage_ready;
    assign accept  = s_valid && s_ready;
    assign over    = (pos_reg >= POS_MAX);

    // row state tracks the input side so the store read can issue at accept
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= '0;
            mode_reg       <= FILT_NONE;
            mode_err_reg   <= 1'b0;
            above_zero_reg <= 1'b1;
        end else if (accept) begin
            if (s_data.row_start) begin
                pos_reg        <= '0;
                above_zero_reg <= s_data.first_row;
                if (s_data.data_byte > FILT_CODE_MAX) begin
                    mode_reg     <= FILT_NONE;
                    mode_err_reg <= 1'b1;
                end else begin
                    mode_reg     <= filt_t'(s_data.data_byte[2:0]);
                    mode_err_reg <= 1'b0;
                end
            end else if (!over) begin
                pos_reg <= pos_reg + 1'b1;
            end
        end
    end

    always_comb begin
        item.data_byte  = s_data.data_byte;
        item.row_start  = s_data.row_start;
        item.mode       = mode_reg;
        item.mode_err   = mode_err_reg;
        item.above_zero = above_zero_reg;
        item.over       = over;
    end

    // A read of position p and the write back of p never meet in the same cycle:
    // the write of p precedes by at least one row-start beat any later read of p,
    // so read-modify-write needs no forwarding path.
    pru_row_store #(
        .DEPTH (MAX_ROW_BYTES),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .wr      (wr),
        .wr_addr (wr_addr),
        .rd_en   (accept && !s_data.row_start),
        .rd_addr (pos_reg[AW-1:0]),
        .rd_data (above_rd)
    );

    pru_recon #(
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES),
        .AW              (AW)
    ) u_recon (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (accept),
        .item_in     (item),
        .addr_in     (pos_reg[AW-1:0]),
        .above_rd    (above_rd),
        .bpp         (bpp_reg),
        .stage_ready (stage_ready),
        .wr          (wr),
        .wr_addr     (wr_addr),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

// ===== tb/png_row_unfilter_top_tb.sv =====
module png_row_unfilter_top_tb;
    import pru_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROW_BYTES   = 8192;
    localparam int PIXEL_BYTES = 8;
    // generous upper bound on the length of the whole run
    localparam int CYCLE_LIMIT = 1000000;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    in_beat_t   s_data    = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    out_beat_t  m_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [3:0] cfg_data  = '0;

    // idle percentages for each side and the long receiver hold-off
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    logic hold_rx     = 1'b0;

    int cycles     = 0;
    int mismatches = 0;

    // expected pixel beats, oldest first
    out_beat_t pixels_due[$];

    // predictor state: a copy of what the unfilter keeps between beats
    logic [7:0] above_row [ROW_BYTES];
    logic [7:0] left_win  [PIXEL_BYTES] = '{default: 8'd0};
    logic [7:0] ul_win    [PIXEL_BYTES] = '{default: 8'd0};
    filt_t      cur_mode   = FILT_NONE;
    logic       mode_bad   = 1'b0;
    logic       above_zero = 1'b1;
    int         byte_pos   = 0;
    logic [3:0] bpp_reg    = BPP_RESET;
    // positions 0 .. store_fill-1 of the row store hold written bytes
    int         store_fill = 0;

    png_row_unfilter_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #6 aclk = ~aclk;

    // Paeth predictor: pick the neighbor closest to a + b - c, ties to a, then b
    function automatic logic [7:0] paeth_predict(logic [7:0] a, logic [7:0] b, logic [7:0] c);
        int ia, ib, ic, p, pa, pb, pc;
        ia = a;
        ib = b;
        ic = c;
        p  = ia + ib - ic;
        pa = (p > ia) ? p - ia : ia - p;
        pb = (p > ib) ? p - ib : ib - p;
        pc = (p > ic) ? p - ic : ic - p;
        if (pa <= pb && pa <= pc)
            return a;
        if (pb <= pc)
            return b;
        return c;
    endfunction

    // Advance the predictor by one accepted beat; queue the pixel it yields.
    function automatic void reconstruct(in_beat_t beat);
        int         span;
        int         k;
        logic       over;
        logic [7:0] left, up, up_left, pix;
        out_beat_t  res;
        if (beat.row_start) begin
            if (beat.data_byte > FILT_CODE_MAX) begin
                cur_mode = FILT_NONE;
                mode_bad = 1'b1;
            end else begin
                cur_mode = filt_t'(beat.data_byte[2:0]);
                mode_bad = 1'b0;
            end
            above_zero = beat.first_row;
            byte_pos   = 0;
            left_win   = '{default: 8'd0};
            ul_win     = '{default: 8'd0};
            return;
        end
        // register value 0 acts as 1, anything past the window acts as the window
        span = (bpp_reg == 0) ? 1 : (bpp_reg > PIXEL_BYTES) ? PIXEL_BYTES : bpp_reg;
        over    = (byte_pos >= ROW_BYTES);
        left    = left_win[span-1];
        up_left = ul_win[span-1];
        up      = (above_zero || over) ? 8'd0 : above_row[byte_pos];
        case (cur_mode)
            FILT_SUB:   pix = beat.data_byte + left;
            FILT_UP:    pix = beat.data_byte + up;
            FILT_AVG:   pix = beat.data_byte + 8'((9'(left) + 9'(up)) >> 1);
            FILT_PAETH: pix = beat.data_byte + paeth_predict(left, up, up_left);
            default:    pix = beat.data_byte;
        endcase
        for (k = PIXEL_BYTES - 1; k > 0; k--) begin
            left_win[k] = left_win[k-1];
            ul_win[k]   = ul_win[k-1];
        end
        left_win[0] = pix;
        ul_win[0]   = up;
        if (!over) begin
            above_row[byte_pos] = pix;
            byte_pos++;
            if (byte_pos > store_fill)
                store_fill = byte_pos;
        end
        res.pixel_byte   = pix;
        res.bad_filter   = mode_bad;
        res.row_overflow = over;
        pixels_due.push_back(res);
    endfunction

    // Offer one beat, hold it until accepted, then predict its result.
    // Valid stays high on return so back-to-back beats need no gap.
    task automatic send_beat(in_beat_t beat);
        while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
        reconstruct(beat);
    endtask

    // fill < 0 draws each byte at random
    task automatic send_bytes(int len, int fill);
        in_beat_t beat;
        int       i;
        for (i = 0; i < len; i++) begin
            beat.data_byte = (fill < 0) ? 8'($urandom) : 8'(fill);
            beat.row_start = 1'b0;
            beat.first_row = 1'($urandom);   // ignored on data beats
            send_beat(beat);
        end
    endtask

    task automatic send_row(logic [7:0] code, logic first, int len, int fill);
        in_beat_t beat;
        beat.data_byte = code;
        beat.row_start = 1'b1;
        beat.first_row = first;
        send_beat(beat);
        send_bytes(len, fill);
    endtask

    // Stop offering beats until every pixel is back, then let the block
    // idle with no beat offered.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pixels_due.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_bpp(logic [3:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        bpp_reg = value;
    endtask

    // Data before any filter byte decodes as None over a zero row.
    task automatic test_data_before_row();
        send_bytes(1, 8'hff);
        send_bytes(1, 8'h00);
        send_bytes(2, -1);
    endtask

    // Every filter type, all-ones and all-zero bytes, then out-of-range codes.
    task automatic test_filter_types();
        send_row(FILT_NONE,  1'b1, 3, 8'hff);
        send_row(FILT_SUB,   1'b0, 3, 8'hff);
        send_row(FILT_UP,    1'b0, 3, 8'h00);
        send_row(FILT_AVG,   1'b0, 3, 8'hff);
        send_row(FILT_PAETH, 1'b0, 3, -1);
        send_row(FILT_CODE_MAX + 8'd1, 1'b0, 2, -1);
        send_row(8'hff, 1'b0, 2, 8'hff);
    endtask

    // Distance register at and past both ends of its range.
    task automatic test_bpp_extremes();
        set_bpp(4'd0);
        send_row(FILT_SUB, 1'b1, 16, -1);
        set_bpp(4'd15);
        send_row(FILT_PAETH, 1'b0, 10, -1);
        set_bpp(4'(PIXEL_BYTES));
        send_row(FILT_AVG, 1'b0, 10, 8'hff);
        set_bpp(4'd1);
        send_row(FILT_PAETH, 1'b0, 10, -1);
    endtask

    // Change the distance inside a row; held bytes take the new distance at once.
    task automatic test_bpp_mid_row();
        send_row(FILT_PAETH, 1'b0, 6, -1);
        set_bpp(4'd5);
        send_bytes(6, -1);
        set_bpp(4'd2);
        send_bytes(4, -1);
    endtask

    // Hold the receiver off long enough for the block to stall its input.
    task automatic test_backpressure();
        int saved_tx;
        saved_tx    = tx_idle_pct;
        tx_idle_pct = 0;
        fork
            begin
                hold_rx <= 1'b1;
                repeat (300) @(posedge aclk);
                hold_rx <= 1'b0;
            end
            send_row(FILT_SUB, 1'b1, 60, -1);
        join
        tx_idle_pct = saved_tx;
        drain_results();
    endtask

    // Mostly well-formed rows with random content; stray filter bytes,
    // bad codes and short rows as noise. Reconfigure now and then.
    task automatic test_random_rows(int n_bytes);
        int         sent;
        int         since_cfg;
        int         kind;
        int         len;
        logic       first;
        logic [7:0] code;
        sent      = 0;
        since_cfg = 0;
        set_bpp(4'($urandom_range(0, 15)));
        while (sent < n_bytes) begin
            kind = $urandom_range(0, 99);
            if (kind < 5) begin
                send_row(8'($urandom), 1'($urandom), 0, -1);
            end else begin
                code  = (kind < 12) ? 8'($urandom_range(FILT_CODE_MAX + 1, 255))
                                    : 8'($urandom_range(0, FILT_CODE_MAX));
                first = (store_fill == 0) || ($urandom_range(0, 99) < 15);
                len   = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 300)
                                                     : $urandom_range(1, 24);
                // never read an above byte that no row has written yet
                if (!first && len > store_fill)
                    len = store_fill;
                send_row(code, first, len, -1);
                sent      += len;
                since_cfg += len;
            end
            if (since_cfg > 250) begin
                set_bpp(4'($urandom_range(0, 15)));
                since_cfg = 0;
            end
        end
    endtask

    // receiver: random stalls, plus the long hold-off on request
    always @(posedge aclk) begin
        m_ready <= !hold_rx && ($urandom_range(0, 99) >= rx_idle_pct);
    end

    task automatic log_mismatch(string what, out_beat_t want, out_beat_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%s: expected byte %02h bad %0b over %0b, got byte %02h bad %0b over %0b",
                     what, want.pixel_byte, want.bad_filter, want.row_overflow,
                     got.pixel_byte, got.bad_filter, got.row_overflow);
    endtask

    // compare each pixel beat with the oldest prediction
    always @(posedge aclk) begin : check_pixels
        out_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pixels_due.size() == 0) begin
                log_mismatch("unexpected pixel", '0, m_data);
            end else begin
                want = pixels_due.pop_front();
                if (m_data.pixel_byte !== want.pixel_byte ||
                    m_data.bad_filter !== want.bad_filter ||
                    m_data.row_overflow !== want.row_overflow)
                    log_mismatch("pixel", want, m_data);
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("png_row_unfilter_top: mismatch");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // sender mostly busy, receiver mostly stalled
        tx_idle_pct = 14;
        rx_idle_pct = 71;
        test_data_before_row();
        test_filter_types();
        test_bpp_extremes();
        test_bpp_mid_row();
        test_backpressure();
        test_random_rows(700);

        // sender mostly idle, receiver mostly ready
        tx_idle_pct = 71;
        rx_idle_pct = 14;
        test_random_rows(700);

        // full rate both ways
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_rows(600);

        drain_results();
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && pixels_due.size() == 0) begin
            $display("png_row_unfilter_top: match");
        end else begin
            $display("png_row_unfilter_top: mismatch");
        end
        $finish;
    end

endmodule

// ===== png_row_unfilter_top.f =====
hw/rtl/pru_pkg.sv
hw/rtl/pru_row_store.sv
hw/rtl/pru_recon.sv
hw/rtl/png_row_unfilter_top.sv
tb/png_row_unfilter_top_tb.sv
